### hdl/tcb_spline_tangents_defines.svh
// ----------------------------------------------------------------------------
// tcb_spline_tangents_defines.svh
// Assertion macros for the TCB spline tangent generator.
// ----------------------------------------------------------------------------
`ifndef TCB_SPLINE_TANGENTS_DEFINES_SVH
`define TCB_SPLINE_TANGENTS_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define TCBST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TCBST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tcbst_pkg.sv
// ----------------------------------------------------------------------------
// tcbst_pkg
// Types, constants and fixed-point helpers of the TCB spline tangent generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcbst_pkg;

	localparam int MAX_POINTS_DEF = 1024;

	localparam int COORD_W   = 32;
	localparam int PAR_W     = 16;
	localparam int IDX_W     = 10;
	localparam int KIND_W    = 2;
	localparam int DIFF_W    = 33;
	localparam int FAC_W     = 17;
	localparam int OPA_W     = 33;
	localparam int OPB_W     = 33;
	localparam int PROD_W    = 56;
	localparam int COEF_W    = 22;
	localparam int STEP_W    = 5;

	localparam int S_TDATA_W = 144;
	localparam int M_FIELD_W = IDX_W + 6 * COORD_W;
	localparam int M_TDATA_W = 208;
	localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

	localparam logic signed [FAC_W-1:0]  ONE_Q14 = 17'sd16384;
	localparam logic signed [PROD_W-1:0] RND27   = 56'sd134217728;
	localparam logic signed [PROD_W:0]   RND13   = 57'sd8192;
	localparam logic signed [PROD_W:0]   RND14   = 57'sd16384;
	localparam logic signed [PROD_W:0]   SAT_HI  = 57'sd2147483647;
	localparam logic signed [PROD_W:0]   SAT_LO  = -57'sd2147483648;

	// Multiplier program: coefficient chain first, then the vector products
	localparam logic [STEP_W-1:0] STEP_M1       = 5'd0;
	localparam logic [STEP_W-1:0] STEP_M2       = 5'd1;
	localparam logic [STEP_W-1:0] STEP_ME       = 5'd2;
	localparam logic [STEP_W-1:0] STEP_KIN_M    = 5'd3;
	localparam logic [STEP_W-1:0] STEP_KIN_P    = 5'd4;
	localparam logic [STEP_W-1:0] STEP_KOUT_M   = 5'd5;
	localparam logic [STEP_W-1:0] STEP_KOUT_P   = 5'd6;
	localparam logic [STEP_W-1:0] STEP_KE       = 5'd7;
	localparam logic [STEP_W-1:0] STEP_VEC      = 5'd8;
	localparam logic [STEP_W-1:0] STEP_LAST_MID = 5'd19;
	localparam logic [STEP_W-1:0] STEP_END      = 5'd20;
	localparam logic [STEP_W-1:0] STEP_LAST_END = 5'd22;

	localparam logic [1:0] TERM_IN_M  = 2'd0;
	localparam logic [1:0] TERM_IN_P  = 2'd1;
	localparam logic [1:0] TERM_OUT_M = 2'd2;
	localparam logic [1:0] TERM_OUT_P = 2'd3;

	typedef enum logic [KIND_W-1:0] {
		KIND_START = 2'd0,
		KIND_INNER = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_DRAIN,
		ST_SEND1,
		ST_SEND2
	} state_t;

	typedef struct packed {
		logic                     vld;
		logic [STEP_W-1:0]        step;
		logic signed [OPA_W-1:0]  a;
		logic signed [OPB_W-1:0]  b;
	} mul_req_t;

	typedef struct packed {
		logic                     vld;
		logic [STEP_W-1:0]        step;
		logic signed [PROD_W-1:0] prod;
	} mul_rsp_t;

	// Q42 product of three factors to a Q14 coefficient, round half up
	function automatic logic signed [COEF_W-1:0] round_coef(
		input logic signed [PROD_W-1:0] p
	);
		logic signed [PROD_W-1:0] s;
		s = p + RND27;
		return COEF_W'(s >>> 28);
	endfunction

	// Q30 sum to Q16.16 with rounding; half selects the extra halving
	function automatic logic [COORD_W-1:0] finish(
		input logic signed [PROD_W:0] sum,
		input logic                   half
	);
		logic signed [PROD_W:0] r;
		logic signed [PROD_W:0] sh;
		r  = sum + (half ? RND14 : RND13);
		sh = half ? (r >>> 15) : (r >>> 14);
		if (sh > SAT_HI) begin
			sh = SAT_HI;
		end else if (sh < SAT_LO) begin
			sh = SAT_LO;
		end
		return sh[COORD_W-1:0];
	endfunction

endpackage

### hdl/tcb_spline_tangents.sv
// ----------------------------------------------------------------------------
// tcb_spline_tangents
// Kochanek-Bartels tangent generator for a stream of 3D control points.
// ----------------------------------------------------------------------------
// One control point per input transfer. The first point of a list is stored
// and gives no output. Every later point is accepted, the multiplier program
// is issued step by step, the last product is written back and then the
// result is transferred; the final point of a list runs a longer program
// and gives two results, the tangents of the point before it and then the
// end tangent. The single 33 x 33 multiplier gives one product a cycle.
// s_tready is low from the accept of a later point until all results are taken.
`timescale 1ns / 1ps
`include "tcb_spline_tangents_defines.svh"

module tcb_spline_tangents #(
	parameter int MAX_POINTS = tcbst_pkg::MAX_POINTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// point_x, point_y, point_z, tension, continuity, bias
	input  logic [tcbst_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// point_index, tangent_in_x/y/z, tangent_out_x/y/z, zero fill
	output logic [tcbst_pkg::M_TDATA_W-1:0]  m_tdata,
	// tangent_kind
	output logic [tcbst_pkg::KIND_W-1:0]     m_tuser,
	output logic                             m_tlast
);
	import tcbst_pkg::*;

	localparam int CntW = $clog2(MAX_POINTS + 1);

	state_t                    state_q, state_d;
	logic [STEP_W-1:0]         step_q;
	logic [STEP_W-1:0]         last_step;
	logic [CntW-1:0]           cnt_q;
	logic [31:0]               n_ext;
	logic                      take;
	kind_t                     kind;

	logic signed [COORD_W-1:0] in_c [3];
	logic signed [PAR_W-1:0]   in_ten, in_con, in_bia;

	logic signed [COORD_W-1:0] cur_q [3];
	logic signed [COORD_W-1:0] prev_q [3];
	logic signed [PAR_W-1:0]   ten_q, con_q, bia_q;

	logic signed [DIFF_W-1:0]  dm_q [3];
	logic signed [DIFF_W-1:0]  dp_q [3];
	logic signed [FAC_W-1:0]   f_mt_q, f_mc_q, f_pc_q, f_mb_q, f_pb_q;
	logic signed [FAC_W-1:0]   f_met_q, f_mec_q, f_peb_q;
	logic                      inner_q, last_q;
	logic [IDX_W-1:0]          idx1_q, idx2_q;

	logic signed [OPA_W-1:0]   m1_q, m2_q, me_q;
	logic signed [COEF_W-1:0]  kin_m_q, kin_p_q, kout_m_q, kout_p_q, ke_q;
	logic signed [PROD_W-1:0]  acc_q;
	logic [COORD_W-1:0]        tin_q [3];
	logic [COORD_W-1:0]        tout_q [3];
	logic [COORD_W-1:0]        tend_q [3];

	mul_req_t                  req;
	mul_rsp_t                  rsp;

	logic [STEP_W-1:0]         vs, es, ws, wes;
	logic [1:0]                vj, vt, ej, wj, wt, wej;
	logic signed [PROD_W:0]    wsum;
	logic [COORD_W-1:0]        wfin, wfin_end;

	assign in_c[0] = s_tdata[31:0];
	assign in_c[1] = s_tdata[63:32];
	assign in_c[2] = s_tdata[95:64];
	assign in_ten  = s_tdata[111:96];
	assign in_con  = s_tdata[127:112];
	assign in_bia  = s_tdata[143:128];

	assign take      = s_tvalid && s_tready;
	assign n_ext     = 32'(cnt_q);
	assign last_step = last_q ? STEP_LAST_END : STEP_LAST_MID;

	// ---------------------------------------------------------------- window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ten_q <= '0;
			con_q <= '0;
			bia_q <= '0;
			for (int j = 0; j < 3; j++) begin
				cur_q[j]  <= '0;
				prev_q[j] <= '0;
			end
		end else if (take) begin
			if (s_tlast) begin
				cnt_q <= '0;
				ten_q <= '0;
				con_q <= '0;
				bia_q <= '0;
				for (int j = 0; j < 3; j++) begin
					cur_q[j]  <= '0;
					prev_q[j] <= '0;
				end
			end else begin
				ten_q <= in_ten;
				con_q <= in_con;
				bia_q <= in_bia;
				for (int j = 0; j < 3; j++) begin
					prev_q[j] <= cur_q[j];
					cur_q[j]  <= in_c[j];
				end
				if (n_ext < 32'(MAX_POINTS)) begin
					cnt_q <= CntW'(n_ext + 32'd1);
				end
			end
		end
	end

	// Capture differences and factors of the point under work
	always_ff @(posedge clk) begin
		if (take) begin
			for (int j = 0; j < 3; j++) begin
				dm_q[j] <= DIFF_W'(cur_q[j]) - DIFF_W'(prev_q[j]);
				dp_q[j] <= DIFF_W'(in_c[j]) - DIFF_W'(cur_q[j]);
			end
			f_mt_q  <= ONE_Q14 - FAC_W'(ten_q);
			f_mc_q  <= ONE_Q14 - FAC_W'(con_q);
			f_pc_q  <= ONE_Q14 + FAC_W'(con_q);
			f_mb_q  <= ONE_Q14 - FAC_W'(bia_q);
			f_pb_q  <= ONE_Q14 + FAC_W'(bia_q);
			f_met_q <= ONE_Q14 - FAC_W'(in_ten);
			f_mec_q <= ONE_Q14 - FAC_W'(in_con);
			f_peb_q <= ONE_Q14 + FAC_W'(in_bia);
			inner_q <= (n_ext > 32'd1);
			last_q  <= s_tlast;
			idx1_q  <= IDX_W'(n_ext - 32'd1);
			idx2_q  <= (n_ext >= 32'(MAX_POINTS)) ? IDX_W'(32'(MAX_POINTS) - 32'd1)
			                                      : IDX_W'(n_ext);
		end
	end

	// ------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_q == ST_CALC) ? step_q + 1'b1 : '0;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		m_tlast  = 1'b0;
		kind     = inner_q ? KIND_INNER : KIND_START;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (take && cnt_q != '0) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (step_q == last_step) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_SEND1;
			end
			ST_SEND1: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = last_q ? ST_SEND2 : ST_IDLE;
				end
			end
			ST_SEND2: begin
				m_tvalid = 1'b1;
				m_tlast  = 1'b1;
				kind     = KIND_END;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------ operands
	always_comb begin
		req.vld  = (state_q == ST_CALC);
		req.step = step_q;
		req.a    = '0;
		req.b    = '0;
		vs       = step_q - STEP_VEC;
		vj       = vs[3:2];
		vt       = vs[1:0];
		es       = step_q - STEP_END;
		ej       = es[1:0];
		priority if (step_q < STEP_VEC) begin
			unique case (step_q)
				STEP_M1: begin
					req.a = OPA_W'(f_mt_q);
					req.b = OPB_W'(f_mc_q);
				end
				STEP_M2: begin
					req.a = OPA_W'(f_mt_q);
					req.b = OPB_W'(f_pc_q);
				end
				STEP_ME: begin
					req.a = OPA_W'(f_met_q);
					req.b = OPB_W'(f_mec_q);
				end
				STEP_KIN_M: begin
					req.a = m1_q;
					req.b = OPB_W'(f_pb_q);
				end
				STEP_KIN_P: begin
					req.a = m2_q;
					req.b = OPB_W'(f_mb_q);
				end
				STEP_KOUT_M: begin
					req.a = m2_q;
					req.b = OPB_W'(f_pb_q);
				end
				STEP_KOUT_P: begin
					req.a = m1_q;
					req.b = OPB_W'(f_mb_q);
				end
				STEP_KE: begin
					req.a = me_q;
					req.b = OPB_W'(f_peb_q);
				end
				default: begin
					req.a = '0;
					req.b = '0;
				end
			endcase
		end else if (step_q < STEP_END) begin
			// a start point uses only the forward difference of the outgoing side
			unique case (vt)
				TERM_IN_M: begin
					req.a = inner_q ? OPA_W'(kin_m_q) : '0;
					req.b = dm_q[vj];
				end
				TERM_IN_P: begin
					req.a = inner_q ? OPA_W'(kin_p_q) : '0;
					req.b = dp_q[vj];
				end
				TERM_OUT_M: begin
					req.a = inner_q ? OPA_W'(kout_m_q) : '0;
					req.b = dm_q[vj];
				end
				TERM_OUT_P: begin
					req.a = OPA_W'(kout_p_q);
					req.b = dp_q[vj];
				end
				default: begin
					req.a = '0;
					req.b = '0;
				end
			endcase
		end else begin
			req.a = OPA_W'(ke_q);
			req.b = dp_q[ej];
		end
	end

	tcbst_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// ------------------------------------------------------------ write-back
	assign ws       = rsp.step - STEP_VEC;
	assign wj       = ws[3:2];
	assign wt       = ws[1:0];
	assign wes      = rsp.step - STEP_END;
	assign wej      = wes[1:0];
	assign wsum     = (PROD_W+1)'(acc_q) + (PROD_W+1)'($signed(rsp.prod));
	assign wfin     = finish(wsum, inner_q);
	assign wfin_end = finish((PROD_W+1)'($signed(rsp.prod)), 1'b0);

	always_ff @(posedge clk) begin
		if (rsp.vld) begin
			priority if (rsp.step < STEP_VEC) begin
				unique case (rsp.step)
					STEP_M1:     m1_q     <= OPA_W'(rsp.prod);
					STEP_M2:     m2_q     <= OPA_W'(rsp.prod);
					STEP_ME:     me_q     <= OPA_W'(rsp.prod);
					STEP_KIN_M:  kin_m_q  <= round_coef(rsp.prod);
					STEP_KIN_P:  kin_p_q  <= round_coef(rsp.prod);
					STEP_KOUT_M: kout_m_q <= round_coef(rsp.prod);
					STEP_KOUT_P: kout_p_q <= round_coef(rsp.prod);
					STEP_KE:     ke_q     <= round_coef(rsp.prod);
					default: begin
					end
				endcase
			end else if (rsp.step < STEP_END) begin
				unique case (wt)
					TERM_IN_M:  acc_q      <= rsp.prod;
					TERM_IN_P:  tin_q[wj]  <= wfin;
					TERM_OUT_M: acc_q      <= rsp.prod;
					TERM_OUT_P: tout_q[wj] <= wfin;
					default: begin
					end
				endcase
			end else begin
				tend_q[wej] <= wfin_end;
			end
		end
	end

	// ---------------------------------------------------------------- output
	always_comb begin
		if (state_q == ST_SEND2) begin
			m_tdata = {{M_PAD_W{1'b0}}, {(3 * COORD_W){1'b0}},
			           tend_q[2], tend_q[1], tend_q[0], idx2_q};
		end else begin
			m_tdata = {{M_PAD_W{1'b0}}, tout_q[2], tout_q[1], tout_q[0],
			           tin_q[2], tin_q[1], tin_q[0], idx1_q};
		end
	end

	assign m_tuser = kind;

	// ------------------------------------------------------------ assertions
	`TCBST_ASSERT_IMP(a_no_take_while_pending, m_tvalid, !s_tready, "input taken while a result waits")
	`TCBST_ASSERT_NXT(a_point_starts_calc, (take && cnt_q != '0), state_q == ST_CALC, "point after the first did not start work")
	`TCBST_ASSERT_IMP(a_last_is_end, (m_tvalid && m_tlast), m_tuser == KIND_END, "last transfer is not an end result")
	`TCBST_ASSERT_IMP(a_step_in_range, state_q == ST_CALC, step_q <= STEP_LAST_END, "multiplier step beyond program")

endmodule

### hdl/tcbst_mul.sv
// ----------------------------------------------------------------------------
// tcbst_mul
// Shared signed multiplier with a registered product and step tag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcbst_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  tcbst_pkg::mul_req_t req,
	output tcbst_pkg::mul_rsp_t rsp
);
	import tcbst_pkg::*;

	logic signed [OPA_W+OPB_W-1:0] full;
	logic                          vld_s1;
	logic [STEP_W-1:0]             step_s1;
	logic signed [PROD_W-1:0]      prod_s1;

	assign full = $signed(req.a) * $signed(req.b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
		end
	end

	always_ff @(posedge clk) begin
		step_s1 <= req.step;
		prod_s1 <= full[PROD_W-1:0];
	end

	assign rsp.vld  = vld_s1;
	assign rsp.step = step_s1;
	assign rsp.prod = prod_s1;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the TCB spline tangent generator. Control point
// lists go in on the slave stream. A local model of the tangent arithmetic
// predicts each result, and every output transfer is compared field by field
// against the oldest prediction. Both stream sides idle at random outside the steady-stream test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import tcbst_pkg::*;

	localparam int     IDLE_PCT   = 36;
	localparam int     QUIET_MAX  = 5000;
	localparam int     SETTLE     = 30;
	localparam longint UNIT_Q14   = 16384;
	localparam int     RAND_ITEMS = 800;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [15:0]      tension;
		logic [15:0]      continuity;
		logic [15:0]      bias;
		logic             is_last;
	} point_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		kind_t            kind;
		logic [2:0][31:0] tin;
		logic [2:0][31:0] tout;
		logic             is_last;
	} tangent_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]    m_tuser;
	logic                 m_tlast;

	tangent_t    expected_tangents[$];
	int          errors = 0;
	int          quiet = 0;
	bit          calm = 1'b0;

	// window of the model: previous and current point, current parameters
	logic signed [31:0] prev_pos[3];
	logic signed [31:0] cur_pos[3];
	logic signed [15:0] cur_t, cur_c, cur_b;
	int unsigned        taken;

	tcb_spline_tangents dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// tangent arithmetic
	// ------------------------------------------------------------------
	function automatic longint blend_coef(longint f1, longint f2, longint f3);
		return (f1 * f2 * f3 + 64'sd134217728) >>> 28;
	endfunction

	function automatic logic [31:0] round_q30(longint v, int sh);
		longint r;
		r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
		if (r > 64'sd2147483647) begin
			r = 64'sd2147483647;
		end else if (r < -64'sd2147483648) begin
			r = -64'sd2147483648;
		end
		return r[31:0];
	endfunction

	function automatic logic [IDX_W-1:0] cap_index(int unsigned n);
		if (n > MAX_POINTS_DEF - 1) begin
			n = MAX_POINTS_DEF - 1;
		end
		return n[IDX_W-1:0];
	endfunction

	function automatic void clear_window();
		for (int j = 0; j < 3; j++) begin
			prev_pos[j] = '0;
			cur_pos[j] = '0;
		end
		cur_t = '0;
		cur_c = '0;
		cur_b = '0;
		taken = 0;
	endfunction

	function automatic void predict_tangents(point_t p);
		longint   ft, fc, fb, k, kin_m, kin_p, kout_m, kout_p, dm, dp;
		tangent_t r;
		r = '0;
		if (taken == 0) begin
			if (!p.is_last) begin
				for (int j = 0; j < 3; j++) begin
					cur_pos[j] = p.pos[j];
				end
				cur_t = p.tension;
				cur_c = p.continuity;
				cur_b = p.bias;
				taken = 1;
			end else begin
				clear_window();
			end
			return;
		end
		ft = longint'(cur_t);
		fc = longint'(cur_c);
		fb = longint'(cur_b);
		if (taken == 1) begin
			k = blend_coef(UNIT_Q14 - ft, UNIT_Q14 - fc, UNIT_Q14 - fb);
			r.kind = KIND_START;
			for (int j = 0; j < 3; j++) begin
				dp = longint'($signed(p.pos[j])) - longint'(cur_pos[j]);
				r.tout[j] = round_q30(k * dp, 14);
			end
		end else begin
			kin_m  = blend_coef(UNIT_Q14 - ft, UNIT_Q14 - fc, UNIT_Q14 + fb);
			kin_p  = blend_coef(UNIT_Q14 - ft, UNIT_Q14 + fc, UNIT_Q14 - fb);
			kout_m = blend_coef(UNIT_Q14 - ft, UNIT_Q14 + fc, UNIT_Q14 + fb);
			kout_p = blend_coef(UNIT_Q14 - ft, UNIT_Q14 - fc, UNIT_Q14 - fb);
			r.index = cap_index(taken - 1);
			r.kind = KIND_INNER;
			for (int j = 0; j < 3; j++) begin
				dm = longint'(cur_pos[j]) - longint'(prev_pos[j]);
				dp = longint'($signed(p.pos[j])) - longint'(cur_pos[j]);
				r.tin[j]  = round_q30(kin_m * dm + kin_p * dp, 15);
				r.tout[j] = round_q30(kout_m * dm + kout_p * dp, 15);
			end
		end
		expected_tangents = {expected_tangents, r};

		if (p.is_last) begin
			// end tangent uses the parameters of the arriving point
			r = '0;
			k = blend_coef(UNIT_Q14 - longint'($signed(p.tension)),
				UNIT_Q14 - longint'($signed(p.continuity)),
				UNIT_Q14 + longint'($signed(p.bias)));
			r.index = cap_index(taken);
			r.kind = KIND_END;
			r.is_last = 1'b1;
			for (int j = 0; j < 3; j++) begin
				dp = longint'($signed(p.pos[j])) - longint'(cur_pos[j]);
				r.tin[j] = round_q30(k * dp, 14);
			end
			expected_tangents = {expected_tangents, r};
			clear_window();
		end else begin
			for (int j = 0; j < 3; j++) begin
				prev_pos[j] = cur_pos[j];
				cur_pos[j] = p.pos[j];
			end
			cur_t = p.tension;
			cur_c = p.continuity;
			cur_b = p.bias;
			if (taken < MAX_POINTS_DEF) begin
				taken = taken + 1;
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic point_t make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [15:0] t, logic [15:0] c, logic [15:0] b, logic is_last);
		point_t p;
		p.pos[0] = x;
		p.pos[1] = y;
		p.pos[2] = z;
		p.tension = t;
		p.continuity = c;
		p.bias = b;
		p.is_last = is_last;
		return p;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom) >>> $urandom_range(20, 4));
			2: return $urandom_range(1) ? (32'h7fffffff ^ $urandom_range(255))
				: (32'h80000000 | $urandom_range(255));
			default: return 32'($urandom_range(2097152)) - 32'd1048576;
		endcase
	endfunction

	function automatic logic [15:0] rand_param();
		case ($urandom_range(7))
			0: return 16'h4000;
			1: return 16'hc000;
			2: return 16'($urandom);
			default: return 16'($urandom_range(32768)) - 16'd16384;
		endcase
	endfunction

	function automatic point_t rand_point(logic is_last);
		return make_point(rand_coord(), rand_coord(), rand_coord(),
			rand_param(), rand_param(), rand_param(), is_last);
	endfunction

	// hold tvalid across back-to-back points; drop it only for a gap
	task automatic send_point(point_t p);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {p.bias, p.continuity, p.tension, p.pos};
		s_tlast  <= p.is_last;
		do @(posedge clk); while (!s_tready);
		predict_tangents(p);
	endtask

	task automatic send_list(int len);
		for (int i = 0; i < len; i++) begin
			send_point(rand_point(i == len - 1));
		end
	endtask

	task automatic wait_for_tangents();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_tangents.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed_cases();
		// lone point flagged last: nothing comes out, next list starts clean
		send_point(make_point(32'd1, 32'd2, 32'd3, 16'h0, 16'h0, 16'h0, 1'b1));
		send_point(make_point(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0));
		send_point(make_point(32'h10000, 32'hffff0000, 32'h7fffffff,
			16'h0, 16'h0, 16'h0, 1'b1));
		// coordinate extremes with doubled and zeroed factors
		send_point(make_point(32'h7fffffff, 32'h80000000, 32'h0,
			16'hc000, 16'hc000, 16'hc000, 1'b0));
		send_point(make_point(32'h80000000, 32'h7fffffff, 32'hffffffff,
			16'h4000, 16'h4000, 16'h4000, 1'b0));
		send_point(make_point(32'h7fffffff, 32'h80000000, 32'h0,
			16'h8000, 16'h7fff, 16'h8000, 1'b1));
		// parameters far outside minus one to one
		send_point(make_point(32'h00012345, 32'hfffe0000, 32'h00000001,
			16'h7fff, 16'h8000, 16'h7fff, 1'b0));
		send_point(make_point(32'hffff8000, 32'h00030000, 32'h80000000,
			16'h8000, 16'h8000, 16'h8000, 1'b0));
		send_point(make_point(32'h40000000, 32'hc0000000, 32'h7fffffff,
			16'h7fff, 16'h7fff, 16'h7fff, 1'b0));
		send_point(make_point(32'h0, 32'h0, 32'h0,
			16'h0, 16'h4000, 16'hc000, 1'b0));
		send_point(make_point(32'hffffffff, 32'h1, 32'h80000001,
			16'hc000, 16'h0, 16'h4000, 1'b1));
		// plain two-point list
		send_point(make_point(32'h00010000, 32'h00020000, 32'h00030000,
			16'h2000, 16'he000, 16'h1000, 1'b0));
		send_point(make_point(32'h00050000, 32'hfffd0000, 32'h00030001,
			16'h1000, 16'h2000, 16'he000, 1'b1));
		wait_for_tangents();
	endtask

	task automatic test_random_lists();
		int sent;
		int len;
		sent = 0;
		while (sent < RAND_ITEMS) begin
			// mostly proper lists; now and then a lone point
			len = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 2);
			send_list(len);
			sent += len;
		end
		wait_for_tangents();
	endtask

	task automatic test_steady_stream();
		calm = 1'b1;
		for (int i = 0; i < 12; i++) begin
			send_list($urandom_range(10, 2));
		end
		wait_for_tangents();
		calm = 1'b0;
	endtask

	task automatic test_long_list();
		// run past the index ceiling so it saturates
		send_list(MAX_POINTS_DEF + 6);
		wait_for_tangents();
	endtask

	// ------------------------------------------------------------------
	// result checking and output back-pressure
	// ------------------------------------------------------------------
	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		tangent_t want;
		tangent_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.index   = m_tdata[IDX_W-1:0];
			got.tin     = m_tdata[IDX_W +: 96];
			got.tout    = m_tdata[IDX_W + 96 +: 96];
			got.kind    = kind_t'(m_tuser);
			got.is_last = m_tlast;
			if (expected_tangents.size() == 0) begin
				$error("result transfer with no tangent pending");
				errors++;
			end else begin
				want = expected_tangents.pop_front();
				check_field("point_index", 32'(want.index), 32'(got.index));
				check_field("tangent_kind", 32'(want.kind), 32'(got.kind));
				check_field("tangent_in_x", want.tin[0], got.tin[0]);
				check_field("tangent_in_y", want.tin[1], got.tin[1]);
				check_field("tangent_in_z", want.tin[2], got.tin[2]);
				check_field("tangent_out_x", want.tout[0], got.tout[0]);
				check_field("tangent_out_y", want.tout[1], got.tout[1]);
				check_field("tangent_out_z", want.tout[2], got.tout[2]);
				check_field("last_result", 32'(want.is_last), 32'(got.is_last));
			end
		end
		m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : watchdog
		while (quiet < QUIET_MAX) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		m_tready <= 1'b0;
		clear_window();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_lists();
		test_steady_stream();
		test_long_list();

		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
